>>> sv/scmb_pkg.sv
// Shared types, constants and companding functions for the soft-clip mu-law block.
package scmb_pkg;

	localparam int SampleW = 24;
	localparam int GainW = 16;
	localparam int ProdW = SampleW + GainW;
	localparam int MagW = 22;
	localparam int X2W = 24;
	localparam int NumW = 48;
	localparam int DenW = 27;
	localparam int QuotW = 24;
	localparam int YW = 21;
	localparam int PcmW = 16;
	localparam int QDepth = 4;
	localparam int QPtrW = $clog2(QDepth);
	localparam int AddrW = 4;

	localparam logic [AddrW-1:0] AddrGain = 4'd0;
	localparam logic [AddrW-1:0] AddrBypass = 4'd4;
	localparam logic [AddrW-1:0] AddrGainSel = 4'd8;

	localparam logic [GainW-1:0] GainReset = 16'd4096;
	localparam logic [ProdW-1:0] ClipLimit = 40'd3 << 35;
	localparam logic [DenW-1:0] K27 = 27'd27 << 20;
	localparam logic [YW-1:0] YOne = 21'd1 << 20;
	localparam logic [14:0] PcmScale = 15'd32767;
	localparam logic [13:0] UlawClip = 14'd8159;
	localparam logic [13:0] UlawBiasQ = 14'd33;
	localparam logic [8:0] UlawBias = 9'h084;
	localparam logic [7:0] MaskNeg = 8'h7f;
	localparam logic [7:0] MaskPos = 8'hff;
	localparam logic [7:0] SegTop = 8'h7f;
	localparam logic [3:0] MantMask = 4'h0f;

	typedef struct packed {
		logic bypass;
		logic neg;
		logic clip;
		logic [MagW-1:0] mag;
		logic [SampleW-1:0] raw;
	} scmb_job_t;

	function automatic logic [7:0] ulaw_encode(input logic signed [PcmW-1:0] pcm);
		logic signed [13:0] v;
		logic [13:0] a;
		logic [7:0] mask;
		logic [3:0] seg;
		logic [3:0] mant;
		logic [7:0] code;
		v = pcm[PcmW-1:2];
		if (v < 0) begin
			a = 14'(-v);
			mask = MaskNeg;
		end else begin
			a = v;
			mask = MaskPos;
		end
		if (a > UlawClip) a = UlawClip;
		a = a + UlawBiasQ;
		seg = 4'd8;
		for (int i = 7; i >= 0; i--) begin
			if (a <= 14'((14'h40 << i) - 14'd1)) seg = 4'(i);
		end
		mant = 4'((a >> (seg + 4'd1)) & 14'(MantMask));
		if (seg == 4'd8) code = SegTop ^ mask;
		else code = {1'b0, seg[2:0], mant} ^ mask;
		return code;
	endfunction

	function automatic logic signed [PcmW-1:0] ulaw_decode(input logic [7:0] code);
		logic [7:0] u;
		logic [15:0] t;
		u = ~code;
		t = 16'({5'd0, u[3:0], 3'd0} + 16'(UlawBias));
		t = t << u[6:4];
		if (u[7]) return PcmW'(16'(UlawBias) - t);
		return PcmW'(t - 16'(UlawBias));
	endfunction

endpackage

>>> sv/scmb_if.sv
// Input and output stream interfaces.
interface scmb_in_if;
	logic valid;
	logic ready;
	logic [scmb_pkg::SampleW-1:0] sample_in;
	logic [scmb_pkg::GainW-1:0] sample_gain;
	modport source(output valid, output sample_in, output sample_gain, input ready);
	modport sink(input valid, input sample_in, input sample_gain, output ready);
endinterface

interface scmb_out_if;
	logic valid;
	logic ready;
	logic [scmb_pkg::SampleW-1:0] sample_out;
	modport source(output valid, output sample_out, input ready);
	modport sink(input valid, input sample_out, output ready);
endinterface

>>> sv/softclip_mulaw_bitcrush.sv
// Top level: configuration registers, front end, job queue and back end.
//
//  channel  dir  payload                         handshake
//  din      in   sample_in[23:0], sample_gain    valid/ready
//  dout     out  sample_out[23:0]                valid/ready
//  apb      in   gain @0x0, bypass @0x4, gsel @0x8
//
// A computed item passes through pop, square, numerator, the 24-step serial divider,
// scale and output; a clipped item goes from pop to scale, a bypassed one to output.
// The front accepts while the four-entry queue has room, so input and output stall apart.
// Reset clears control state and loads the register defaults.
module softclip_mulaw_bitcrush (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [scmb_pkg::AddrW-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	scmb_in_if.sink din,
	scmb_out_if.source dout
);
	logic [scmb_pkg::GainW-1:0] gain_q;
	logic bypass_q;
	logic gsel_q;
	logic q_full, q_empty, q_push, q_pop;
	scmb_pkg::scmb_job_t wjob, rjob;

	assign pready = 1'b1;

	always_comb begin
		case (paddr)
			scmb_pkg::AddrGain: prdata = {{16{gain_q[15]}}, gain_q};
			scmb_pkg::AddrBypass: prdata = {31'd0, bypass_q};
			scmb_pkg::AddrGainSel: prdata = {31'd0, gsel_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= scmb_pkg::GainReset;
			bypass_q <= 1'b0;
			gsel_q <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr)
				scmb_pkg::AddrGain: gain_q <= pwdata[15:0];
				scmb_pkg::AddrBypass: bypass_q <= pwdata[0];
				scmb_pkg::AddrGainSel: gsel_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	scmb_front u_front (
		.din(din),
		.gain(gain_q),
		.bypass(bypass_q),
		.gain_sel(gsel_q),
		.q_full(q_full),
		.q_push(q_push),
		.q_job(wjob)
	);

	scmb_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata(wjob),
		.pop(q_pop),
		.rdata(rjob),
		.full(q_full),
		.empty(q_empty)
	);

	scmb_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_job(rjob),
		.q_pop(q_pop),
		.dout(dout)
	);
endmodule

>>> sv/scmb_front.sv
// Front end: accept items, apply gain and classify into jobs.
module scmb_front (
	scmb_in_if.sink din,
	input logic [scmb_pkg::GainW-1:0] gain,
	input logic bypass,
	input logic gain_sel,
	input logic q_full,
	output logic q_push,
	output scmb_pkg::scmb_job_t q_job
);
	logic signed [scmb_pkg::GainW-1:0] g;
	logic signed [scmb_pkg::ProdW-1:0] p;
	logic [scmb_pkg::ProdW-1:0] ap;

	assign din.ready = !q_full;
	assign q_push = din.valid && !q_full;
	assign g = gain_sel ? din.sample_gain : gain;
	assign p = $signed(din.sample_in) * g;
	assign ap = p[scmb_pkg::ProdW-1] ? scmb_pkg::ProdW'(-p) : p;

	always_comb begin
		q_job.bypass = bypass;
		q_job.neg = p[scmb_pkg::ProdW-1];
		q_job.clip = ap > scmb_pkg::ClipLimit;
		q_job.mag = ap[15 +: scmb_pkg::MagW];
		q_job.raw = din.sample_in;
	end
endmodule

>>> sv/scmb_queue.sv
// Short job queue between front and back.
module scmb_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input scmb_pkg::scmb_job_t wdata,
	input logic pop,
	output scmb_pkg::scmb_job_t rdata,
	output logic full,
	output logic empty
);
	scmb_pkg::scmb_job_t mem_q [scmb_pkg::QDepth];
	logic [scmb_pkg::QPtrW-1:0] wp_q, rp_q;
	logic [scmb_pkg::QPtrW:0] cnt_q;

	assign full = cnt_q == (scmb_pkg::QPtrW+1)'(scmb_pkg::QDepth);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

>>> sv/scmb_back.sv
// Back end: soft clip with serial divider, mu-law round trip, output register.
module scmb_back (
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	input scmb_pkg::scmb_job_t q_job,
	output logic q_pop,
	scmb_out_if.source dout
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SQ   = 6'b000010,
		S_NUM  = 6'b000100,
		S_DIV  = 6'b001000,
		S_PCM  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t st_q;
	scmb_pkg::scmb_job_t job_q;
	logic [scmb_pkg::X2W-1:0] x2_q;
	logic [scmb_pkg::DenW-1:0] den_q;
	logic [scmb_pkg::DenW-1:0] rem_q;
	logic [scmb_pkg::QuotW-1:0] lo_q;
	logic [4:0] cnt_q;
	logic [scmb_pkg::PcmW-1:0] mag_q;
	logic out_v_q;
	logic [scmb_pkg::SampleW-1:0] out_d_q;

	logic [2*scmb_pkg::MagW-1:0] sq;
	logic [scmb_pkg::NumW-1:0] num;
	logic [scmb_pkg::DenW:0] trial;
	logic [scmb_pkg::YW-1:0] ysat;
	logic [scmb_pkg::YW+14:0] scaled;
	logic signed [scmb_pkg::PcmW-1:0] pcm;
	logic signed [scmb_pkg::PcmW-1:0] dec;
	logic out_free;

	assign sq = job_q.mag * job_q.mag;
	assign num = scmb_pkg::NumW'(job_q.mag)
		* scmb_pkg::NumW'(scmb_pkg::K27 + scmb_pkg::DenW'(x2_q));
	assign trial = {rem_q, lo_q[scmb_pkg::QuotW-1]};
	assign ysat = job_q.clip ? scmb_pkg::YOne
		: (lo_q > scmb_pkg::QuotW'(scmb_pkg::YOne)) ? scmb_pkg::YOne
		: lo_q[scmb_pkg::YW-1:0];
	assign scaled = ysat * scmb_pkg::PcmScale;
	assign pcm = job_q.neg ? scmb_pkg::PcmW'(-mag_q) : mag_q;
	assign dec = scmb_pkg::ulaw_decode(scmb_pkg::ulaw_encode(pcm));
	assign out_free = !out_v_q || dout.ready;
	assign q_pop = (st_q == S_IDLE) && !q_empty;
	assign dout.valid = out_v_q;
	assign dout.sample_out = out_d_q;

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: job_q <= q_job;
			S_SQ: x2_q <= sq[20 +: scmb_pkg::X2W];
			S_NUM: begin
				den_q <= scmb_pkg::K27 + scmb_pkg::DenW'(x2_q) * 27'd9;
				rem_q <= scmb_pkg::DenW'(num[scmb_pkg::NumW-1:scmb_pkg::QuotW]);
				lo_q <= num[scmb_pkg::QuotW-1:0];
			end
			S_DIV: begin
				if (trial >= {1'b0, den_q}) begin
					rem_q <= scmb_pkg::DenW'(trial - {1'b0, den_q});
					lo_q <= {lo_q[scmb_pkg::QuotW-2:0], 1'b1};
				end else begin
					rem_q <= trial[scmb_pkg::DenW-1:0];
					lo_q <= {lo_q[scmb_pkg::QuotW-2:0], 1'b0};
				end
			end
			S_PCM: mag_q <= scmb_pkg::PcmW'(scaled >> 20);
			S_OUT: if (out_free) begin
				out_d_q <= job_q.bypass ? job_q.raw : {dec, 8'd0};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if ((st_q == S_OUT) && out_free) out_v_q <= 1'b1;
			else if (dout.ready) out_v_q <= 1'b0;
			case (st_q)
				S_IDLE: if (!q_empty) begin
					if (q_job.bypass) st_q <= S_OUT;
					else if (q_job.clip) st_q <= S_PCM;
					else st_q <= S_SQ;
				end
				S_SQ: st_q <= S_NUM;
				S_NUM: begin
					cnt_q <= '0;
					st_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'(scmb_pkg::QuotW - 1)) st_q <= S_PCM;
				end
				S_PCM: st_q <= S_OUT;
				S_OUT: if (out_free) begin
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> sv/scmb_checker.sv
// Port-level assertions for the top level and their bind.
module scmb_checker (
	input logic clk,
	input logic arst_n,
	input logic pready,
	input logic out_valid,
	input logic out_ready,
	input logic [scmb_pkg::SampleW-1:0] sample_out
);
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out))
		else $error("output item changed while stalled");

	a_pready: assert property (@(posedge clk) pready)
		else $error("pready low");

	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("output item right after reset");
endmodule

bind softclip_mulaw_bitcrush scmb_checker u_scmb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.pready(pready),
	.out_valid(dout.valid),
	.out_ready(dout.ready),
	.sample_out(dout.sample_out)
);
